// ===== hw/rtl/svf_pkg.sv =====
`timescale 1ns / 1ps
// svf_pkg: shared types, codes and defaults of the state variable filter
// used by svf_ctrl, svf_dp, state_variable_filter and svf_check
package svf_pkg;

  // default widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STATE_BITS_DEF  = 24;

  // fraction bits of the multiplier constants
  localparam int COEFF_FRAC = 14;
  localparam int DAMP_FRAC  = 15;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COEFF_W     = 15;
  localparam int DAMP_W      = 16;
  localparam int MODE_W      = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FREQ_COEFF   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_Q    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_DAMPING = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 2'd3;

  localparam logic [COEFF_W-1:0] FREQ_COEFF_RST   = 15'd0;
  localparam logic [DAMP_W-1:0]  DAMPING_Q_RST    = 16'd32768;
  localparam logic [DAMP_W-1:0]  BAND_DAMPING_RST = 16'd32440;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOW    = 3'd0,
    MODE_HIGH   = 3'd1,
    MODE_BAND   = 3'd2,
    MODE_NOTCH  = 3'd3,
    MODE_BYPASS = 3'd4
  } mode_t;

  // operand pair for the shared multiplier
  typedef enum logic [1:0] {
    MS_BAND_Q = 2'd0,
    MS_BAND_C = 2'd1,
    MS_HIGH_C = 2'd2,
    MS_TMP_D  = 2'd3
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load_x;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     wr_notch;
    logic     wr_low;
    logic     wr_high;
    logic     wr_tmp;
    logic     wr_band;
    logic     wr_out;
  } cmd_t;

endpackage

// ===== hw/rtl/svf_ctrl.sv =====
`timescale 1ns / 1ps
// svf_ctrl: sequencer of the state variable filter, owns both handshakes
// depends on svf_pkg
module svf_ctrl
  import svf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MQ    = 10'b00_0000_0010,
    S_NOTCH = 10'b00_0000_0100,
    S_LOW   = 10'b00_0000_1000,
    S_HIGH  = 10'b00_0001_0000,
    S_MHC   = 10'b00_0010_0000,
    S_TMP   = 10'b00_0100_0000,
    S_MBD   = 10'b00_1000_0000,
    S_BAND  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MS_BAND_Q;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_next = S_MQ;
        end
      end
      S_MQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_BAND_Q;
        state_next  = S_NOTCH;
      end
      S_NOTCH: begin
        cmd.wr_notch = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_BAND_C;
        state_next   = S_LOW;
      end
      S_LOW: begin
        cmd.wr_low = 1'b1;
        state_next = S_HIGH;
      end
      S_HIGH: begin
        cmd.wr_high = 1'b1;
        state_next  = S_MHC;
      end
      S_MHC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_HIGH_C;
        state_next  = S_TMP;
      end
      S_TMP: begin
        cmd.wr_tmp = 1'b1;
        state_next = S_MBD;
      end
      S_MBD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TMP_D;
        state_next  = S_BAND;
      end
      S_BAND: begin
        cmd.wr_band = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.wr_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.wr_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hw/rtl/svf_dp.sv =====
`timescale 1ns / 1ps
// svf_dp: registers, shared multiplier, saturating adders and mode select
// depends on svf_pkg, driven by svf_ctrl commands
module svf_dp
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int ST = STATE_BITS;
  localparam int PW = ST + DAMP_W + 1;  // product width
  localparam int WW = ST + 5;           // working width of sums

  localparam logic signed [PW:0] HALF_C = (PW + 1)'(1) << (COEFF_FRAC - 1);
  localparam logic signed [PW:0] HALF_D = (PW + 1)'(1) << (DAMP_FRAC - 1);

  localparam logic signed [WW-1:0] ST_MAX_W = {{(WW - ST + 1){1'b0}}, {(ST - 1){1'b1}}};
  localparam logic signed [WW-1:0] ST_MIN_W = {{(WW - ST + 1){1'b1}}, {(ST - 1){1'b0}}};
  localparam logic signed [ST-1:0] SB_MAX_S = {{(ST - SB + 1){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [ST-1:0] SB_MIN_S = {{(ST - SB + 1){1'b1}}, {(SB - 1){1'b0}}};

  function automatic logic signed [ST-1:0] sat_st(input logic signed [WW-1:0] v);
    logic signed [ST-1:0] r;
    if (v > ST_MAX_W) begin
      r = ST_MAX_W[ST-1:0];
    end else if (v < ST_MIN_W) begin
      r = ST_MIN_W[ST-1:0];
    end else begin
      r = v[ST-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SB-1:0] sat_sb(input logic signed [ST-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SB_MAX_S) begin
      r = SB_MAX_S[SB-1:0];
    end else if (v < SB_MIN_S) begin
      r = SB_MIN_S[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [COEFF_W-1:0] freq_coeff;
  logic [DAMP_W-1:0]  damping_q;
  logic [DAMP_W-1:0]  band_damping;
  logic [MODE_W-1:0]  filter_mode;

  // filter state and per-item values
  logic signed [ST-1:0] lowpass_acc;
  logic signed [ST-1:0] bandpass_acc;
  logic signed [ST-1:0] x_reg;
  logic signed [ST-1:0] notch;
  logic signed [ST-1:0] high;
  logic signed [ST-1:0] band_tmp;
  logic signed [PW-1:0] prod;

  logic signed [ST-1:0] mul_a;
  logic [DAMP_W-1:0]    mul_b;
  logic signed [PW:0]   rnd_c;
  logic signed [PW:0]   rnd_d;
  logic signed [WW-1:0] prod_c;   // product scaled by the coeff fraction
  logic signed [WW-1:0] prod_d;   // product scaled by the damping fraction
  logic signed [ST-1:0] sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coeff   <= FREQ_COEFF_RST;
      damping_q    <= DAMPING_Q_RST;
      band_damping <= BAND_DAMPING_RST;
      filter_mode  <= MODE_LOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FREQ_COEFF:   freq_coeff   <= cfg_data[COEFF_W-1:0];
        REG_DAMPING_Q:    damping_q    <= cfg_data[DAMP_W-1:0];
        REG_BAND_DAMPING: band_damping <= cfg_data[DAMP_W-1:0];
        REG_FILTER_MODE:  filter_mode  <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      MS_BAND_Q: begin
        mul_a = bandpass_acc;
        mul_b = damping_q;
      end
      MS_BAND_C: begin
        mul_a = bandpass_acc;
        mul_b = DAMP_W'(freq_coeff);
      end
      MS_HIGH_C: begin
        mul_a = high;
        mul_b = DAMP_W'(freq_coeff);
      end
      MS_TMP_D: begin
        mul_a = band_tmp;
        mul_b = band_damping;
      end
      default: begin
        mul_a = bandpass_acc;
        mul_b = damping_q;
      end
    endcase
  end

  // round half up, then floor shift
  assign rnd_c  = {prod[PW-1], prod} + HALF_C;
  assign rnd_d  = {prod[PW-1], prod} + HALF_D;
  assign prod_c = {rnd_c[PW], rnd_c[PW:COEFF_FRAC]};
  assign prod_d = {{2{rnd_d[PW]}}, rnd_d[PW:DAMP_FRAC]};

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_reg <= ST'(sample_in);
    end
    if (cmd.mul_en) begin
      prod <= PW'(mul_a) * PW'($signed({1'b0, mul_b}));
    end
    if (cmd.wr_notch) begin
      notch <= sat_st(WW'(x_reg) - prod_d);
    end
    if (cmd.wr_high) begin
      high <= sat_st(WW'(notch) - WW'(lowpass_acc));
    end
    if (cmd.wr_tmp) begin
      band_tmp <= sat_st(WW'(bandpass_acc) + prod_c);
    end
    if (cmd.wr_out) begin
      sample_out <= sat_sb(sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowpass_acc  <= '0;
      bandpass_acc <= '0;
    end else begin
      if (cmd.wr_low) begin
        lowpass_acc <= sat_st(WW'(lowpass_acc) + prod_c);
      end
      if (cmd.wr_band) begin
        bandpass_acc <= sat_st(prod_d);
      end
    end
  end

  // unused mode codes pass the input through
  always_comb begin
    unique case (filter_mode)
      MODE_LOW:   sel = lowpass_acc;
      MODE_HIGH:  sel = high;
      MODE_BAND:  sel = bandpass_acc;
      MODE_NOTCH: sel = notch;
      default:    sel = x_reg;
    endcase
  end

endmodule

// ===== hw/rtl/state_variable_filter.sv =====
`timescale 1ns / 1ps
// state_variable_filter: top level of the two-integrator audio filter
// depends on svf_pkg, svf_ctrl and svf_dp
//
// Chamberlin-style state variable filter for one signed Q1.15 audio stream.
// Per item it computes notch = x - q*band, low += coeff*band,
// high = notch - low, band = (band + coeff*high) * band_damping, with every
// intermediate saturated to STATE_BITS and each product rounded half up, then
// returns the lowpass, highpass, bandpass or notch value, or the input in
// bypass (mode codes 5 to 7 also act as bypass), saturated to the sample
// width. Both integrators advance on every item in every mode. Coefficients
// come through the write port: index 0 freq_coeff (Q1.14), 1 damping_q
// (Q1.15), 2 band_damping (Q1.15), 3 filter_mode; write them only while no
// item is in flight. One signed multiplier is shared by all four products,
// so an item walks through the idle step that accepts it, the four
// multiplies and their adds in sequence, and one output load into the
// result register. The block works on one item at a time and takes the next
// item as soon as the result is loaded, even while that result still waits
// on out_ready; a new result that is ready while the old one is still
// unclaimed holds in the output step until out_ready. STATE_BITS must not be
// below SAMPLE_BITS.

module state_variable_filter
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  // register writes
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  // command bundle from the sequencer to the datapath
  cmd_t cmd;

  // sequencer: walks the multiply and add steps, owns valid and ready
  svf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: config registers, integrators, shared multiplier, output register
  svf_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

// ===== hw/rtl/svf_check.sv =====
`timescale 1ns / 1ps
// svf_check: port-level assertions for state_variable_filter
// depends on svf_pkg, bound to the top level below
module svf_check
  import svf_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sample_out
);

  // a result waiting on the sink holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("result changed or dropped while stalled");

  // one item at a time: no second item right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is being filtered");

  // a new result only appears at the end of a busy period
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item being worked on");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind state_variable_filter svf_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_svf_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);
